/* rtl/core/i2cms_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master command sequencer package
// Item types, action, event and bus phase codes shared by the core files.
// ----------------------------------------------------------------------------
package i2cms_pkg;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] slave_addr;
		logic [7:0] rx_count;
		logic       task_tail;
		logic [7:0] tx_byte;
		logic [2:0] event_code;
		logic [7:0] bus_rx_byte;
	} i2cms_in_t;

	typedef struct packed {
		logic       accepted;
		logic       issue_start;
		logic       issue_stop;
		logic       ack_off;
		logic       soft_reset;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       rx_valid;
		logic [7:0] rx_index;
		logic [7:0] rx_data;
		logic       task_done;
		logic [3:0] bus_state;
	} i2cms_out_t;

	localparam logic [2:0] ACT_STAGE   = 3'd0;
	localparam logic [2:0] ACT_COMMIT  = 3'd1;
	localparam logic [2:0] ACT_START   = 3'd2;
	localparam logic [2:0] ACT_EVENT   = 3'd3;
	localparam logic [2:0] ACT_BUS_ERR = 3'd4;
	localparam logic [2:0] ACT_REINIT  = 3'd5;

	localparam logic [2:0] EV_START_DONE  = 3'd0;
	localparam logic [2:0] EV_TX_ADDR_ACK = 3'd1;
	localparam logic [2:0] EV_RX_ADDR_ACK = 3'd2;
	localparam logic [2:0] EV_BYTE_RX     = 3'd3;
	localparam logic [2:0] EV_BYTE_SENT   = 3'd4;

	localparam logic [3:0] PH_FREE  = 4'd0;
	localparam logic [3:0] PH_START = 4'd1;
	localparam logic [3:0] PH_ADDR  = 4'd2;
	localparam logic [3:0] PH_TXMOD = 4'd3;
	localparam logic [3:0] PH_TX    = 4'd4;
	localparam logic [3:0] PH_RXMOD = 4'd5;
	localparam logic [3:0] PH_RX    = 4'd6;
	localparam logic [3:0] PH_STOP  = 4'd7;
	localparam logic [3:0] PH_ERROR = 4'd8;

	localparam logic [7:0] LIMIT_RESET = 8'd100;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_STAGE,
		OP_COMMIT,
		OP_START,
		OP_EVENT,
		OP_BUS_ERR,
		OP_REINIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] slave_addr;
		logic [7:0] rx_count;
		logic       task_tail;
		logic [7:0] tx_byte;
		logic [2:0] ev_code;
		logic [7:0] rx_byte;
	} cmd_t;

endpackage
`default_nettype wire

/* rtl/core/i2c_master_command_sequencer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master command sequencer
// Command queue and bus event sequencer for an I2C master controller.
//
//   channel  handshake                 payload
//   cmd      cmd_valid / cmd_ready     cmd   (i2cms_in_t)
//   rsp      rsp_valid / rsp_ready     rsp   (i2cms_out_t)
//   limit    limit_we                  limit_wdata (watchdog limit)
//
// Stage, bus error, reinit, unused action, refused commit or start: result
// registered at dequeue; start that launches: via S_LAUNCH. Bus event: S_EVENT
// (transmit buffer and command table read), then S_LAUNCH when a completed
// command launches the next one. Commit: staged bytes copied in S_COPY (one
// byte a cycle), then table write. Two items queue in front of the executor,
// which takes no new item while a result waits. No clearing pass after reset.
// ----------------------------------------------------------------------------
module i2c_master_command_sequencer #(
	parameter int QUEUE_DEPTH = 8,
	parameter int MAX_TX      = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_ready,
	input  wire i2cms_pkg::i2cms_in_t  cmd,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output i2cms_pkg::i2cms_out_t      rsp,
	input  wire logic                  limit_we,
	input  wire logic [7:0]            limit_wdata
);
	import i2cms_pkg::*;

	logic q_valid;
	logic q_pop;
	cmd_t q_item;

	i2cms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	i2cms_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAX_TX      (MAX_TX)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.limit_we    (limit_we),
		.limit_wdata (limit_wdata),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp)
	);

endmodule
`default_nettype wire

/* rtl/core/i2cms_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module i2cms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* rtl/core/i2cms_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// I2C sequencer front end
// Accepts items, decodes the action and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module i2cms_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_ready,
	input  wire i2cms_pkg::i2cms_in_t  cmd,
	output logic                       q_valid,
	output i2cms_pkg::cmd_t            q_item,
	input  wire logic                  q_pop
);
	import i2cms_pkg::*;

	cmd_t       dec;
	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	always_comb begin
		dec.slave_addr = cmd.slave_addr;
		dec.rx_count   = cmd.rx_count;
		dec.task_tail  = cmd.task_tail;
		dec.tx_byte    = cmd.tx_byte;
		dec.ev_code    = cmd.event_code;
		dec.rx_byte    = cmd.bus_rx_byte;
		case (cmd.action)
			ACT_STAGE:   dec.op = OP_STAGE;
			ACT_COMMIT:  dec.op = OP_COMMIT;
			ACT_START:   dec.op = OP_START;
			ACT_EVENT:   dec.op = OP_EVENT;
			ACT_BUS_ERR: dec.op = OP_BUS_ERR;
			ACT_REINIT:  dec.op = OP_REINIT;
			default:     dec.op = OP_NONE;
		endcase
	end

	assign cmd_ready = (cnt_q != 2'd2);
	assign push      = cmd_valid && cmd_ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_item    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/core/i2cms_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// I2C sequencer back end
// Executes decoded items: staging, command queue, bus event steps, watchdog.
// ----------------------------------------------------------------------------
module i2cms_back #(
	parameter int QUEUE_DEPTH = 8,
	parameter int MAX_TX      = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  limit_we,
	input  wire logic [7:0]            limit_wdata,
	input  wire logic                  q_valid,
	input  wire i2cms_pkg::cmd_t       q_item,
	output logic                       q_pop,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output i2cms_pkg::i2cms_out_t      rsp
);
	import i2cms_pkg::*;

	localparam int SW  = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int TLW = $clog2(MAX_TX + 1);
	localparam int SAW = (MAX_TX > 1) ? $clog2(MAX_TX) : 1;
	localparam int TXD = QUEUE_DEPTH * MAX_TX;
	localparam int TAW = $clog2(TXD);
	localparam int MW  = 17 + TLW;

	localparam logic [SW-1:0]  LAST_SLOT = SW'(QUEUE_DEPTH - 1);
	localparam logic [TLW-1:0] MAX_TX_C  = TLW'(MAX_TX);
	localparam logic [CW:0]    DEPTH_C   = (CW + 1)'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_COPY,
		S_EVENT,
		S_LAUNCH
	} state_t;

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [TAW-1:0] tx_addr(input logic [SW-1:0] s, input logic [SAW-1:0] i);
		return TAW'(int'(s) * MAX_TX + int'(i));
	endfunction

	state_t     state_q, state_n;
	cmd_t       cmd_q, cmd_n;
	logic [SW-1:0]  head_q, head_n, tail_q, tail_n, slot_q, slot_n;
	logic [CW-1:0]  count_q, count_n;
	logic [TLW-1:0] sc_q, sc_n, cp_cnt_q, cp_cnt_n;
	logic           cp_v_s1, cp_v_n;
	logic [SAW-1:0] cp_idx_s1, cp_idx_n;
	logic [7:0]     bi_q, bi_n, wd_q, wd_n, limit_q;
	logic           reading_q, reading_n;
	logic [3:0]     phase_q, phase_n;
	logic           from_start_q, from_start_n;
	i2cms_out_t     pend_q, pend_n, rsp_q, rsp_n, res;
	logic           rsp_valid_q, rsp_valid_n, emit;

	logic           st_we, tx_we, meta_we;
	logic [7:0]     st_rdata, tx_rdata;
	logic [SW-1:0]  meta_raddr;
	logic [MW-1:0]  meta_rdata, meta_wdata;
	logic [7:0]     m_addr, m_rxl;
	logic [TLW-1:0] m_txl;
	logic           m_tail;

	logic           hold;
	logic [8:0]     w9;
	logic [7:0]     txv, bi_inc;
	logic           done_cmd;

	assign m_addr = meta_rdata[MW-1 -: 8];
	assign m_rxl  = meta_rdata[MW-9 -: 8];
	assign m_txl  = meta_rdata[TLW:1];
	assign m_tail = meta_rdata[0];
	assign meta_wdata = {cmd_q.slave_addr, cmd_q.rx_count, sc_q, cmd_q.task_tail};
	assign meta_raddr = (state_q == S_IDLE && q_item.op == OP_EVENT) ? slot_q : head_q;

	i2cms_ram #(.WIDTH(8), .DEPTH(MAX_TX)) u_stage_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (sc_q[SAW-1:0]),
		.wdata (q_item.tx_byte),
		.raddr (cp_cnt_q[SAW-1:0]),
		.rdata (st_rdata)
	);

	i2cms_ram #(.WIDTH(8), .DEPTH(TXD)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_addr(tail_q, cp_idx_s1)),
		.wdata (st_rdata),
		.raddr (tx_addr(slot_q, bi_q[SAW-1:0])),
		.rdata (tx_rdata)
	);

	i2cms_ram #(.WIDTH(MW), .DEPTH(QUEUE_DEPTH)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (tail_q),
		.wdata (meta_wdata),
		.raddr (meta_raddr),
		.rdata (meta_rdata)
	);

	always_comb begin
		state_n      = state_q;
		cmd_n        = cmd_q;
		head_n       = head_q;
		tail_n       = tail_q;
		slot_n       = slot_q;
		count_n      = count_q;
		sc_n         = sc_q;
		cp_cnt_n     = cp_cnt_q;
		cp_v_n       = 1'b0;
		cp_idx_n     = cp_idx_s1;
		bi_n         = bi_q;
		wd_n         = wd_q;
		reading_n    = reading_q;
		phase_n      = phase_q;
		from_start_n = from_start_q;
		pend_n       = pend_q;
		res          = '0;
		emit         = 1'b0;
		q_pop        = 1'b0;
		st_we        = 1'b0;
		tx_we        = 1'b0;
		meta_we      = 1'b0;
		done_cmd     = 1'b0;
		hold         = (phase_q != PH_FREE);
		w9           = {1'b0, wd_q} + 9'd1;
		txv          = (bi_q < 8'(m_txl)) ? tx_rdata : 8'd0;
		bi_inc       = bi_q + 8'd1;

		case (state_q)
			S_IDLE: begin
				if (q_valid && !rsp_valid_q) begin
					q_pop = 1'b1;
					cmd_n = q_item;
					case (q_item.op)
						OP_STAGE: begin
							if (sc_q < MAX_TX_C) begin
								st_we = 1'b1;
								sc_n  = sc_q + 1'b1;
							end
							emit = 1'b1;
						end
						OP_COMMIT: begin
							if (({1'b0, count_q} + (CW + 1)'(hold)) < DEPTH_C) begin
								cp_cnt_n = '0;
								state_n  = S_COPY;
							end else begin
								emit = 1'b1;
							end
						end
						OP_START: begin
							if (phase_q == PH_FREE && count_q != '0) begin
								from_start_n = 1'b1;
								pend_n       = '0;
								state_n      = S_LAUNCH;
							end else begin
								emit = 1'b1;
							end
						end
						OP_EVENT: state_n = S_EVENT;
						OP_BUS_ERR: begin
							res.soft_reset = 1'b1;
							phase_n        = PH_ERROR;
							emit           = 1'b1;
						end
						OP_REINIT: begin
							res.soft_reset = 1'b1;
							head_n         = '0;
							tail_n         = '0;
							count_n        = '0;
							phase_n        = PH_FREE;
							emit           = 1'b1;
						end
						default: emit = 1'b1;
					endcase
				end
			end
			S_COPY: begin
				tx_we = cp_v_s1;
				if (cp_cnt_q < sc_q) begin
					cp_v_n   = 1'b1;
					cp_idx_n = cp_cnt_q[SAW-1:0];
					cp_cnt_n = cp_cnt_q + 1'b1;
				end else if (!cp_v_s1) begin
					meta_we      = 1'b1;
					tail_n       = next_slot(tail_q);
					count_n      = count_q + 1'b1;
					sc_n         = '0;
					res.accepted = 1'b1;
					emit         = 1'b1;
					state_n      = S_IDLE;
				end
			end
			S_EVENT: begin
				wd_n = w9[7:0];
				if (w9 > {1'b0, limit_q}) begin
					phase_n        = PH_ERROR;
					res.soft_reset = 1'b1;
					wd_n           = '0;
				end
				case (cmd_q.ev_code)
					EV_START_DONE: begin
						phase_n        = PH_ADDR;
						bi_n           = '0;
						res.send_valid = 1'b1;
						res.send_byte  = {m_addr[7:1], reading_q};
					end
					EV_TX_ADDR_ACK: begin
						phase_n        = PH_TXMOD;
						res.send_valid = 1'b1;
						res.send_byte  = txv;
						bi_n           = bi_inc;
					end
					EV_RX_ADDR_ACK: begin
						phase_n = PH_RXMOD;
						if (m_rxl <= 8'd1) begin
							res.ack_off    = 1'b1;
							res.issue_stop = 1'b1;
						end
					end
					EV_BYTE_RX: begin
						phase_n      = PH_RX;
						res.rx_valid = 1'b1;
						res.rx_index = bi_q;
						res.rx_data  = cmd_q.rx_byte;
						bi_n         = bi_inc;
						if ({1'b0, m_rxl} == ({1'b0, bi_inc} + 9'd1)) begin
							res.ack_off    = 1'b1;
							res.issue_stop = 1'b1;
						end else if (m_rxl == bi_inc) begin
							done_cmd = 1'b1;
						end
					end
					EV_BYTE_SENT: begin
						if (bi_q < 8'(m_txl)) begin
							phase_n        = PH_TX;
							res.send_valid = 1'b1;
							res.send_byte  = txv;
							bi_n           = bi_inc;
						end else if (m_rxl != 8'd0) begin
							phase_n         = PH_START;
							bi_n            = '0;
							reading_n       = 1'b1;
							res.issue_start = 1'b1;
						end else begin
							res.issue_stop = 1'b1;
							done_cmd       = 1'b1;
						end
					end
					default: ;
				endcase
				state_n = S_IDLE;
				if (done_cmd) begin
					wd_n          = '0;
					res.task_done = m_tail;
					phase_n       = PH_FREE;
					if (count_q != '0) begin
						from_start_n = 1'b0;
						pend_n       = res;
						state_n      = S_LAUNCH;
					end
				end
				emit = (state_n == S_IDLE);
			end
			S_LAUNCH: begin
				slot_n          = head_q;
				head_n          = next_slot(head_q);
				count_n         = count_q - 1'b1;
				phase_n         = PH_START;
				bi_n            = '0;
				reading_n       = (m_txl == '0);
				res             = pend_q;
				res.issue_start = 1'b1;
				res.accepted    = from_start_q;
				emit            = 1'b1;
				state_n         = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase

		rsp_valid_n = rsp_valid_q && !rsp_ready;
		rsp_n       = rsp_q;
		if (emit) begin
			rsp_n           = res;
			rsp_n.bus_state = phase_n;
			rsp_valid_n     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			slot_q       <= '0;
			count_q      <= '0;
			sc_q         <= '0;
			cp_cnt_q     <= '0;
			cp_v_s1      <= 1'b0;
			cp_idx_s1    <= '0;
			bi_q         <= '0;
			wd_q         <= '0;
			limit_q      <= LIMIT_RESET;
			reading_q    <= 1'b0;
			phase_q      <= PH_FREE;
			from_start_q <= 1'b0;
			pend_q       <= '0;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_n;
			cmd_q        <= cmd_n;
			head_q       <= head_n;
			tail_q       <= tail_n;
			slot_q       <= slot_n;
			count_q      <= count_n;
			sc_q         <= sc_n;
			cp_cnt_q     <= cp_cnt_n;
			cp_v_s1      <= cp_v_n;
			cp_idx_s1    <= cp_idx_n;
			bi_q         <= bi_n;
			wd_q         <= wd_n;
			if (limit_we) begin
				limit_q <= limit_wdata;
			end
			reading_q    <= reading_n;
			phase_q      <= phase_n;
			from_start_q <= from_start_n;
			pend_q       <= pend_n;
			rsp_q        <= rsp_n;
			rsp_valid_q  <= rsp_valid_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

/* rtl/core/i2cms_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// I2C sequencer port checker
// Result channel rules seen at the top level ports.
// ----------------------------------------------------------------------------
module i2cms_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  rsp_valid,
	input wire logic                  rsp_ready,
	input wire i2cms_pkg::i2cms_out_t rsp
);
	import i2cms_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_send_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.send_valid |-> rsp.send_byte == 8'd0)
		else $error("send byte set without send valid");

	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.rx_valid |-> rsp.rx_index == 8'd0 && rsp.rx_data == 8'd0)
		else $error("rx fields set without rx valid");

	a_start_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.issue_start |-> rsp.bus_state == PH_START)
		else $error("start issued outside start phase");

endmodule

bind i2c_master_command_sequencer i2cms_checker u_i2cms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire
